### rtl/qvr_pkg.sv
// Shared types and widths for the quaternion vector rotation pipeline.
package qvr_pkg;

    localparam int QUAT_W = 16;
    localparam int VEC_W  = 16;
    localparam int PROD_W = 2 * QUAT_W;           // signed quat*quat product
    localparam int N_W    = PROD_W + 1;           // |q|^2, unsigned
    localparam int M_W    = PROD_W + 2;           // rotation matrix entry, signed
    localparam int MV_W   = M_W + VEC_W;          // matrix entry times vector component
    localparam int NUM_W  = MV_W + 2;             // row sum, signed
    localparam int MAG_W  = NUM_W - 1;            // row sum magnitude
    localparam int QW     = VEC_W;                // quotient magnitude bits
    localparam int LANES  = 3;

    typedef struct packed {
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
        logic signed [VEC_W-1:0]  vx;
        logic signed [VEC_W-1:0]  vy;
        logic signed [VEC_W-1:0]  vz;
    } item_t;

    // one divider transaction: three numerators sharing one divisor
    typedef struct packed {
        logic [LANES-1:0]            sign;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [N_W-1:0]              norm;
        logic                        zero;
    } div_in_t;

    typedef struct packed {
        logic [LANES-1:0]            sign;
        logic [LANES-1:0][MAG_W-1:0] rem;
        logic [LANES-1:0][QW-1:0]    quo;
        logic [N_W-1:0]              norm;
        logic                        zero;
    } div_st_t;

endpackage

### rtl/quaternion_vector_rotate.sv
// Path from input transaction to result: 4 arithmetic stages, 16 divider stages, 1 output
// register. Throughput: one transaction per cycle when the output is not stalled; the divider
// pipeline retires one quotient bit per stage for all three components at once.
// Stalls back up stage by stage; empty stages keep filling while the output waits.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
module quaternion_vector_rotate import qvr_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,  // rot_x, rot_y, rot_z
    output logic [1:0]    m_tuser   // zero_quat, saturated
);

    localparam logic [QW-1:0] POS_MAX = QW'((1 << (VEC_W-1)) - 1);
    localparam logic [QW-1:0] NEG_MAX = QW'(1 << (VEC_W-1));

    item_t   item;
    logic    f_valid, f_ready;
    div_in_t f_data;
    logic    d_valid, d_ready;
    div_st_t d_data;

    logic                        out_valid_reg;
    logic [LANES-1:0][VEC_W-1:0] rot_reg, rot_next;
    logic                        zero_reg, sat_reg, sat_next;

    assign item.qx = s_tdata[15:0];
    assign item.qy = s_tdata[31:16];
    assign item.qz = s_tdata[47:32];
    assign item.qw = s_tdata[63:48];
    assign item.vx = s_tdata[79:64];
    assign item.vy = s_tdata[95:80];
    assign item.vz = s_tdata[111:96];

    qvr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    qvr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    assign d_ready = !out_valid_reg || m_tready;

    // truncated magnitude, signed and clipped; a zero quaternion gives zero
    always_comb begin
        sat_next = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (d_data.zero) begin
                rot_next[l] = '0;
            end else if (!d_data.sign[l] && d_data.quo[l] > POS_MAX) begin
                rot_next[l] = POS_MAX;
                sat_next    = 1'b1;
            end else if (d_data.sign[l] && d_data.quo[l] > NEG_MAX) begin
                rot_next[l] = NEG_MAX;
                sat_next    = 1'b1;
            end else if (d_data.sign[l]) begin
                rot_next[l] = VEC_W'(-d_data.quo[l]);
            end else begin
                rot_next[l] = VEC_W'(d_data.quo[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (d_ready) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && d_valid) begin
            rot_reg  <= rot_next;
            zero_reg <= d_data.zero;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {rot_reg[2], rot_reg[1], rot_reg[0]};
    assign m_tuser  = {sat_reg, zero_reg};

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && m_tdata == '0)
        else $error("zero quaternion result not cleared");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[15:0] == POS_MAX || m_tdata[15:0] == NEG_MAX ||
            m_tdata[31:16] == POS_MAX || m_tdata[31:16] == NEG_MAX ||
            m_tdata[47:32] == POS_MAX || m_tdata[47:32] == NEG_MAX)
        else $error("saturation flagged without a clipped component");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !d_valid && !f_valid)
        else $error("pipeline valid after reset");

endmodule

### rtl/qvr_front.sv
// Front pipeline: products, rotation matrix, matrix-vector products, row sums.
module qvr_front import qvr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output div_in_t out_data
);

    typedef struct packed {
        logic signed [PROD_W-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        logic signed [VEC_W-1:0]  vx, vy, vz;
    } s1_t;

    typedef struct packed {
        logic [2:0][2:0][M_W-1:0] m;
        logic [N_W-1:0]           norm;
        logic signed [VEC_W-1:0]  vx, vy, vz;
    } s2_t;

    typedef struct packed {
        logic [2:0][2:0][MV_W-1:0] mv;
        logic [N_W-1:0]            norm;
    } s3_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    s3_t     s3_reg, s3_next;
    div_in_t s4_reg, s4_next;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

    always_comb begin
        s1_next.xx = in_item.qx * in_item.qx;
        s1_next.yy = in_item.qy * in_item.qy;
        s1_next.zz = in_item.qz * in_item.qz;
        s1_next.ww = in_item.qw * in_item.qw;
        s1_next.xy = in_item.qx * in_item.qy;
        s1_next.xz = in_item.qx * in_item.qz;
        s1_next.yz = in_item.qy * in_item.qz;
        s1_next.wx = in_item.qw * in_item.qx;
        s1_next.wy = in_item.qw * in_item.qy;
        s1_next.wz = in_item.qw * in_item.qz;
        s1_next.vx = in_item.vx;
        s1_next.vy = in_item.vy;
        s1_next.vz = in_item.vz;
    end

    always_comb begin
        logic signed [M_W-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        xx = M_W'(s1_reg.xx); yy = M_W'(s1_reg.yy);
        zz = M_W'(s1_reg.zz); ww = M_W'(s1_reg.ww);
        xy = M_W'(s1_reg.xy); xz = M_W'(s1_reg.xz); yz = M_W'(s1_reg.yz);
        wx = M_W'(s1_reg.wx); wy = M_W'(s1_reg.wy); wz = M_W'(s1_reg.wz);
        s2_next.norm    = N_W'(xx + yy + zz + ww);
        s2_next.m[0][0] = ww + xx - yy - zz;
        s2_next.m[0][1] = (xy - wz) <<< 1;
        s2_next.m[0][2] = (xz + wy) <<< 1;
        s2_next.m[1][0] = (xy + wz) <<< 1;
        s2_next.m[1][1] = ww - xx + yy - zz;
        s2_next.m[1][2] = (yz - wx) <<< 1;
        s2_next.m[2][0] = (xz - wy) <<< 1;
        s2_next.m[2][1] = (yz + wx) <<< 1;
        s2_next.m[2][2] = ww - xx - yy + zz;
        s2_next.vx = s1_reg.vx;
        s2_next.vy = s1_reg.vy;
        s2_next.vz = s1_reg.vz;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_next.mv[i][0] = MV_W'($signed(s2_reg.m[i][0]) * s2_reg.vx);
            s3_next.mv[i][1] = MV_W'($signed(s2_reg.m[i][1]) * s2_reg.vy);
            s3_next.mv[i][2] = MV_W'($signed(s2_reg.m[i][2]) * s2_reg.vz);
        end
        s3_next.norm = s2_reg.norm;
    end

    always_comb begin
        logic signed [NUM_W-1:0] sum;
        for (int i = 0; i < LANES; i++) begin
            sum = NUM_W'($signed(s3_reg.mv[i][0])) + NUM_W'($signed(s3_reg.mv[i][1]))
                + NUM_W'($signed(s3_reg.mv[i][2]));
            s4_next.sign[i] = sum[NUM_W-1];
            s4_next.mag[i]  = sum[NUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        end
        s4_next.norm = s3_reg.norm;
        s4_next.zero = (s3_reg.norm == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) s1_reg <= s1_next;
        if (adv2 && v1_reg)   s2_reg <= s2_next;
        if (adv3 && v2_reg)   s3_reg <= s3_next;
        if (adv4 && v3_reg)   s4_reg <= s4_next;
    end

endmodule

### rtl/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes.
module qvr_div import qvr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  div_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output div_st_t out_data
);

    logic [QW-1:0] vld_reg;
    logic [QW-1:0] adv;
    div_st_t       st_reg [QW];
    div_st_t       init;

    always_comb begin
        init.sign = in_data.sign;
        init.rem  = in_data.mag;
        init.quo  = '0;
        init.norm = in_data.norm;
        init.zero = in_data.zero;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        div_st_t cur, st_next;
        logic    cur_valid;
        logic    nxt_ready;

        if (k == 0) begin : g_first
            assign cur       = init;
            assign cur_valid = in_valid;
        end else begin : g_mid
            assign cur       = st_reg[k-1];
            assign cur_valid = vld_reg[k-1];
        end

        if (k == QW-1) begin : g_last
            assign nxt_ready = out_ready;
        end else begin : g_inner
            assign nxt_ready = adv[k+1];
        end

        assign adv[k] = !vld_reg[k] || nxt_ready;

        always_comb begin
            logic [MAG_W-1:0] dsh;
            dsh = MAG_W'(cur.norm) << (QW-1-k);
            st_next = cur;
            for (int l = 0; l < LANES; l++) begin
                if (cur.rem[l] >= dsh) begin
                    st_next.rem[l]        = cur.rem[l] - dsh;
                    st_next.quo[l][QW-1-k] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                vld_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k] && cur_valid) st_reg[k] <= st_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[QW-1];
    assign out_data  = st_reg[QW-1];

endmodule
